// ===== hdl/ers_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ers_pkg
// shared types and codes for the elevator request scheduler
// ----------------------------------------------------------------------------
package ers_pkg;

  typedef enum logic {
    ACT_SUBMIT   = 1'b0,
    ACT_COMPLETE = 1'b1
  } action_e;

  typedef enum logic {
    KIND_GRANT  = 1'b0,
    KIND_REJECT = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_AGE,
    ST_DONE
  } state_e;

endpackage

// ===== hdl/ers_cmd_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ers_cmd_fifo
// small command queue between the front end and the scan engine
// ----------------------------------------------------------------------------
module ers_cmd_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  input  logic             pop_i,
  output logic [Width-1:0] pop_data_o,
  output logic             empty_o,
  output logic             full_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [PtrW:0]    cnt_q;

  assign empty_o    = (cnt_q == '0);
  assign full_o     = (cnt_q == (PtrW+1)'(Depth));
  assign pop_data_o = mem_q[rd_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i && !full_o) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i && !empty_o) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (PtrW+1)'(push_i && !full_o) - (PtrW+1)'(pop_i && !empty_o);
    end
  end

endmodule

// ===== hdl/ers_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ers_engine
// request table and scan engine: one entry examined per cycle
// ----------------------------------------------------------------------------
module ers_engine
  import ers_pkg::*;
#(
  parameter int unsigned QueueDepth = 16,
  parameter int unsigned TagBits    = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  logic               cmd_action_i,
  input  logic [31:0]        cmd_sector_i,
  input  logic [TagBits-1:0] cmd_tag_i,
  output logic               cmd_pop_o,
  output logic               res_valid_o,
  output logic               res_kind_o,
  output logic [TagBits-1:0] res_tag_o,
  output logic [31:0]        res_sector_o,
  output logic               res_up_o
);

  localparam int unsigned IdxW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned AgeW = IdxW;

  // table
  logic [QueueDepth-1:0] valid_q;
  logic [31:0]           sec_q [QueueDepth];
  logic [TagBits-1:0]    tag_q [QueueDepth];
  logic [AgeW-1:0]       age_q [QueueDepth];

  logic [IdxW-1:0] svc_q;
  logic            svc_valid_q, up_q;

  state_e state_q, state_d;
  logic [IdxW-1:0] idx_q;
  logic            act_q;
  logic [31:0]     csec_q;
  logic [TagBits-1:0] ctag_q;

  // scan accumulators
  logic            found_q, has_s_q, has_p_q;
  logic [IdxW-1:0] free_q, succ_q, pred_q;
  logic [AgeW-1:0] same_q;
  logic            any_q;

  logic [31:0]     rsec;
  logic [AgeW-1:0] rage;
  logic            last_idx;

  assign rsec     = sec_q[svc_q];
  assign rage     = age_q[svc_q];
  assign last_idx = (idx_q == IdxW'(QueueDepth - 1));

  // comparisons for the entry under scan
  logic [31:0]     esec;
  logic [AgeW-1:0] eage;
  logic            r_less_e, e_less_s, p_less_e;
  assign esec     = sec_q[idx_q];
  assign eage     = age_q[idx_q];
  assign r_less_e = (rsec != esec) ? (rsec < esec) : (rage < eage);
  assign e_less_s = (esec != sec_q[succ_q]) ? (esec < sec_q[succ_q])
                                            : (eage < age_q[succ_q]);
  assign p_less_e = (sec_q[pred_q] != esec) ? (sec_q[pred_q] < esec)
                                            : (age_q[pred_q] < eage);

  // direction decided from the scan
  logic up_new, has_next;
  logic [IdxW-1:0] next_idx;
  always_comb begin
    up_new = up_q;
    if (up_q && !has_s_q) begin
      up_new = 1'b0;
    end else if (!up_q && !has_p_q) begin
      up_new = 1'b1;
    end
    has_next = up_new ? has_s_q : has_p_q;
    next_idx = up_new ? succ_q : pred_q;
  end

  // next state
  always_comb begin
    state_d   = state_q;
    cmd_pop_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          state_d   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last_idx) begin
          state_d = act_q ? ST_AGE : ST_DONE;
        end
      end
      ST_AGE: begin
        if (last_idx) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // control and table update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      svc_q       <= '0;
      svc_valid_q <= 1'b0;
      up_q        <= 1'b1;
      idx_q       <= '0;
      act_q       <= 1'b0;
      found_q     <= 1'b0;
      has_s_q     <= 1'b0;
      has_p_q     <= 1'b0;
      any_q       <= 1'b0;
      res_valid_o <= 1'b0;
      res_kind_o  <= KIND_GRANT;
    end else begin
      state_q     <= state_d;
      res_valid_o <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          idx_q   <= '0;
          found_q <= 1'b0;
          has_s_q <= 1'b0;
          has_p_q <= 1'b0;
          any_q   <= 1'b0;
          if (cmd_valid_i) begin
            act_q <= cmd_action_i;
          end
        end
        ST_SCAN: begin
          if (act_q == ACT_SUBMIT) begin
            if (valid_q[idx_q]) begin
              any_q <= 1'b1;
            end else if (!found_q) begin
              found_q <= 1'b1;
            end
          end else if (valid_q[idx_q] && idx_q != svc_q) begin
            if (r_less_e) begin
              if (!has_s_q || e_less_s) begin
                has_s_q <= 1'b1;
              end
            end else if (!has_p_q || p_less_e) begin
              has_p_q <= 1'b1;
            end
          end
          idx_q <= last_idx ? '0 : idx_q + 1'b1;
        end
        ST_AGE: begin
          idx_q <= last_idx ? '0 : idx_q + 1'b1;
        end
        ST_DONE: begin
          if (act_q == ACT_SUBMIT) begin
            if (!found_q) begin
              res_valid_o <= 1'b1;
              res_kind_o  <= KIND_REJECT;
            end else begin
              valid_q[free_q] <= 1'b1;
              if (!any_q) begin
                svc_q       <= free_q;
                svc_valid_q <= 1'b1;
                res_valid_o <= 1'b1;
                res_kind_o  <= KIND_GRANT;
              end
            end
          end else if (svc_valid_q && valid_q[svc_q]) begin
            up_q           <= up_new;
            valid_q[svc_q] <= 1'b0;
            svc_valid_q    <= has_next;
            if (has_next) begin
              svc_q       <= next_idx;
              res_valid_o <= 1'b1;
              res_kind_o  <= KIND_GRANT;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        same_q <= '0;
        if (cmd_valid_i) begin
          csec_q <= cmd_sector_i;
          ctag_q <= cmd_tag_i;
        end
      end
      ST_SCAN: begin
        if (act_q == ACT_SUBMIT) begin
          if (valid_q[idx_q]) begin
            if (esec == csec_q) begin
              same_q <= same_q + 1'b1;
            end
          end else if (!found_q) begin
            free_q <= idx_q;
          end
        end else if (valid_q[idx_q] && idx_q != svc_q) begin
          if (r_less_e) begin
            if (!has_s_q || e_less_s) begin
              succ_q <= idx_q;
            end
          end else if (!has_p_q || p_less_e) begin
            pred_q <= idx_q;
          end
        end
      end
      ST_AGE: begin
        if (svc_valid_q && valid_q[svc_q] && valid_q[idx_q] && idx_q != svc_q &&
            esec == rsec && eage > rage) begin
          age_q[idx_q] <= eage - 1'b1;
        end
      end
      ST_DONE: begin
        res_up_o <= (act_q == ACT_COMPLETE && svc_valid_q && valid_q[svc_q]) ? up_new
                                                                              : up_q;
        res_tag_o    <= '0;
        res_sector_o <= '0;
        if (act_q == ACT_SUBMIT) begin
          if (found_q) begin
            sec_q[free_q] <= csec_q;
            tag_q[free_q] <= ctag_q;
            age_q[free_q] <= same_q;
            res_tag_o     <= ctag_q;
            res_sector_o  <= csec_q;
          end
        end else begin
          res_tag_o    <= tag_q[next_idx];
          res_sector_o <= sec_q[next_idx];
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== hdl/elevator_request_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elevator_request_scheduler
// LOOK elevator scheduler for one disk request table
// ----------------------------------------------------------------------------
// A command (submit or complete) is taken when start is high and busy is
// low and lands in a two-entry queue; the scan engine handles one command at
// a time, stepping through the table one entry per cycle, and a complete also
// walks the table in an ageing pass over entries on the served sector. At most
// one result per command appears for one cycle with valid_o high; the
// receiver cannot stall it.
module elevator_request_scheduler
  import ers_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned TAG_BITS    = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic                action_i,
  input  logic [31:0]         sector_i,
  input  logic [TAG_BITS-1:0] tag_i,
  output logic                valid_o,
  output logic                kind_o,
  output logic [TAG_BITS-1:0] granted_tag_o,
  output logic [31:0]         granted_sector_o,
  output logic                sweeping_up_o
);

  localparam int unsigned CmdW = 1 + 32 + TAG_BITS;

  logic [CmdW-1:0] head;
  logic empty, full, pop;

  // command queue
  ers_cmd_fifo #(.Width(CmdW), .Depth(2)) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (start && !busy),
    .push_data_i({action_i, sector_i, tag_i}),
    .pop_i      (pop),
    .pop_data_o (head),
    .empty_o    (empty),
    .full_o     (full)
  );

  assign busy = full;

  // scan engine
  ers_engine #(.QueueDepth(QUEUE_DEPTH), .TagBits(TAG_BITS)) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!empty),
    .cmd_action_i(head[CmdW-1]),
    .cmd_sector_i(head[TAG_BITS +: 32]),
    .cmd_tag_i   (head[TAG_BITS-1:0]),
    .cmd_pop_o   (pop),
    .res_valid_o (valid_o),
    .res_kind_o  (kind_o),
    .res_tag_o   (granted_tag_o),
    .res_sector_o(granted_sector_o),
    .res_up_o    (sweeping_up_o)
  );

endmodule

// ===== hdl/ers_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ers_props
// port-level checks for the elevator request scheduler
// ----------------------------------------------------------------------------
module ers_props #(
  parameter int unsigned TAG_BITS = 8
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input logic                valid_o,
  input logic                kind_o,
  input logic [TAG_BITS-1:0] granted_tag_o,
  input logic [31:0]         granted_sector_o
);

  // results never come in adjacent cycles
  a_no_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o) else $error("results in adjacent cycles");

  // a reject carries zero payload
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && kind_o) |-> (granted_tag_o == '0 && granted_sector_o == '0))
    else $error("reject with payload");

  // no result straight after reset
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !valid_o) else $error("result after reset");

  // busy cannot be asserted with no transfer behind it
  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start)) else $error("busy without transfer");

endmodule

bind elevator_request_scheduler ers_props #(.TAG_BITS(TAG_BITS)) u_ers_props (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .valid_o         (valid_o),
  .kind_o          (kind_o),
  .granted_tag_o   (granted_tag_o),
  .granted_sector_o(granted_sector_o)
);

// ===== bench/ers_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ers_checker
// watches the command and result channels, predicts and compares results
// ----------------------------------------------------------------------------
// Every accepted command may update a private copy of the request table and
// may queue one expected result. Each result strobe is compared field by
// field against the oldest expected result.
// ----------------------------------------------------------------------------
module ers_checker
  import ers_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned TAG_BITS    = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  logic                busy,
  input  logic                action_i,
  input  logic [31:0]         sector_i,
  input  logic [TAG_BITS-1:0] tag_i,
  input  logic                valid_o,
  input  logic                kind_o,
  input  logic [TAG_BITS-1:0] granted_tag_o,
  input  logic [31:0]         granted_sector_o,
  input  logic                sweeping_up_o,
  output int                  mismatches_o,
  output int                  waiting_o
);

  typedef struct packed {
    kind_e               kind;
    logic [TAG_BITS-1:0] tag;
    logic [31:0]         sector;
    logic                up;
  } grant_t;

  // scheduler table copy
  logic                slot_used [QUEUE_DEPTH];
  logic [31:0]         slot_sector [QUEUE_DEPTH];
  logic [TAG_BITS-1:0] slot_tag [QUEUE_DEPTH];
  int unsigned         slot_rank [QUEUE_DEPTH];
  int unsigned         serving_slot;
  logic                serving;
  logic                heading_up;
  grant_t              pending_grants[$];

  function automatic bit ahead_of(int unsigned a, int unsigned b);
    if (slot_sector[a] != slot_sector[b]) return slot_sector[a] < slot_sector[b];
    return slot_rank[a] < slot_rank[b];
  endfunction

  function automatic grant_t make_grant(kind_e k, logic [TAG_BITS-1:0] t, logic [31:0] s);
    grant_t g;
    g.kind = k;
    g.tag = t;
    g.sector = s;
    g.up = heading_up;
    return g;
  endfunction

  task automatic take_submit(logic [31:0] s, logic [TAG_BITS-1:0] t);
    int unsigned used, same, free_slot;
    bit found;
    used = 0;
    same = 0;
    free_slot = 0;
    found = 0;
    for (int unsigned i = 0; i < QUEUE_DEPTH; i++) begin
      if (slot_used[i]) begin
        used++;
        if (slot_sector[i] == s) same++;
      end else if (!found) begin
        found = 1;
        free_slot = i;
      end
    end
    if (!found) begin
      pending_grants.push_back(make_grant(KIND_REJECT, '0, '0));
      return;
    end
    slot_used[free_slot] = 1'b1;
    slot_sector[free_slot] = s;
    slot_tag[free_slot] = t;
    slot_rank[free_slot] = same;
    if (used == 0) begin
      serving_slot = free_slot;
      serving = 1'b1;
      pending_grants.push_back(make_grant(KIND_GRANT, t, s));
    end
  endtask

  task automatic take_complete();
    int unsigned r, above, below, nxt;
    bit has_above, has_below, has_next;
    r = serving_slot;
    above = 0;
    below = 0;
    has_above = 0;
    has_below = 0;
    if (!serving || !slot_used[r]) return;
    for (int unsigned i = 0; i < QUEUE_DEPTH; i++) begin
      if (!slot_used[i] || i == r) continue;
      if (ahead_of(r, i)) begin
        if (!has_above || ahead_of(i, above)) begin
          above = i;
          has_above = 1;
        end
      end else begin
        if (!has_below || ahead_of(below, i)) begin
          below = i;
          has_below = 1;
        end
      end
    end
    // reverse at the end of the sweep
    if (heading_up && !has_above) heading_up = 1'b0;
    else if (!heading_up && !has_below) heading_up = 1'b1;
    has_next = heading_up ? has_above : has_below;
    nxt = heading_up ? above : below;
    slot_used[r] = 1'b0;
    for (int unsigned i = 0; i < QUEUE_DEPTH; i++)
      if (slot_used[i] && slot_sector[i] == slot_sector[r] && slot_rank[i] > slot_rank[r])
        slot_rank[i]--;
    if (!has_next) begin
      serving = 1'b0;
      return;
    end
    serving_slot = nxt;
    serving = 1'b1;
    pending_grants.push_back(make_grant(KIND_GRANT, slot_tag[nxt], slot_sector[nxt]));
  endtask

  // compare results, then predict for the accepted transfer
  always @(posedge clk_i or negedge rst_ni) begin
    grant_t want;
    if (!rst_ni) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) slot_used[i] = 1'b0;
      serving_slot = 0;
      serving = 1'b0;
      heading_up = 1'b1;
      mismatches_o <= 0;
      waiting_o <= 0;
      pending_grants.delete();
    end else begin
      if (valid_o) begin
        if (pending_grants.size() == 0) begin
          $display("%0t: unexpected result kind=%0b tag=%0h sector=%0h up=%0b", $time,
                   kind_o, granted_tag_o, granted_sector_o, sweeping_up_o);
          mismatches_o <= mismatches_o + 1;
        end else begin
          want = pending_grants.pop_front();
          if (want.kind !== kind_o || want.tag !== granted_tag_o ||
              want.sector !== granted_sector_o || want.up !== sweeping_up_o) begin
            $display("%0t: expected kind=%0b tag=%0h sector=%0h up=%0b", $time,
                     want.kind, want.tag, want.sector, want.up);
            $display("%0t: actual   kind=%0b tag=%0h sector=%0h up=%0b", $time,
                     kind_o, granted_tag_o, granted_sector_o, sweeping_up_o);
            mismatches_o <= mismatches_o + 1;
          end
        end
      end
      if (start && !busy) begin
        if (action_i == ACT_SUBMIT) take_submit(sector_i, tag_i);
        else take_complete();
      end
      waiting_o <= pending_grants.size();
    end
  end

endmodule

// ===== bench/tb_elevator_request_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_elevator_request_scheduler
// stimulus and verdict for the elevator request scheduler
// ----------------------------------------------------------------------------
// A directed run fills the table to a reject and partly drains it, then random
// submit/complete mixes with varying submit bias, clustered sectors and
// idle bursts exercise sweep reversal and equal-sector ordering.
// ----------------------------------------------------------------------------
module tb_elevator_request_scheduler;
  import ers_pkg::*;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned TBITS = 8;
  localparam int NUM_RANDOM = 930;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic             action_i = ACT_SUBMIT;
  logic [31:0]      sector_i = '0;
  logic [TBITS-1:0] tag_i = '0;
  logic             valid_o;
  logic             kind_o;
  logic [TBITS-1:0] granted_tag_o;
  logic [31:0]      granted_sector_o;
  logic             sweeping_up_o;
  int               mismatches;
  int               waiting;
  logic [31:0]      sector_pool [8];

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  elevator_request_scheduler #(.QUEUE_DEPTH(DEPTH), .TAG_BITS(TBITS)) dut (.*);

  ers_checker #(.QUEUE_DEPTH(DEPTH), .TAG_BITS(TBITS)) u_checker (
    .mismatches_o(mismatches), .waiting_o(waiting), .*
  );

  // one command transfer; start stays high afterwards
  task automatic send(action_e act, logic [31:0] s, logic [TBITS-1:0] t);
    start <= 1'b1;
    action_i <= act;
    sector_i <= s;
    tag_i <= t;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic pause(int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_sector();
    if ($urandom_range(0, 4) == 0) return $urandom();
    return sector_pool[$urandom_range(0, 7)];
  endfunction

  // run limit
  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int unsigned bias;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // complete with nothing in service, then fill to a reject and partly drain
    send(ACT_COMPLETE, 32'h0, 8'h00);
    send(ACT_SUBMIT, 32'hFFFF_FFFF, 8'hFF);
    send(ACT_SUBMIT, 32'h0, 8'h00);
    for (int i = 0; i < 14; i++)
      send(ACT_SUBMIT, (i % 3 == 0) ? 32'd5 : 32'h8000_0000 >> i, 8'(i * 17 + 1));
    send(ACT_SUBMIT, 32'd7, 8'hAA);
    for (int i = 0; i < 6; i++) send(ACT_COMPLETE, 32'h0, 8'h00);

    // random part with drifting submit bias
    bias = 60;
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n % 50 == 0) begin
        bias = $urandom_range(30, 90);
        for (int k = 0; k < 8; k++)
          sector_pool[k] = (k == 0) ? 32'h0 : (k == 1) ? 32'hFFFF_FFFF :
                           ($urandom_range(0, 1) ? $urandom_range(0, 64) : $urandom());
      end
      if (n < NUM_RANDOM - 100 && n % 40 < 25 && $urandom_range(0, 3) == 0)
        pause($urandom_range(1, 12));
      if ($urandom_range(1, 100) <= bias)
        send(ACT_SUBMIT, pick_sector(), TBITS'($urandom()));
      else
        send(ACT_COMPLETE, $urandom(), TBITS'($urandom()));
    end
    start <= 1'b0;

    // let the last predictions settle, then drain the queued commands
    repeat (2) @(posedge clk_i);
    while (waiting != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/ers_pkg.sv
hdl/ers_cmd_fifo.sv
hdl/ers_engine.sv
hdl/elevator_request_scheduler.sv
hdl/ers_checker.sv
bench/ers_checker.sv
bench/tb_elevator_request_scheduler.sv
